// File: design/mht_pkg.sv
// Shared types, constants and helpers of the multichannel hysteresis thermostat.
// No dependencies; every other design file imports this package.
package mht_pkg;

  // Table geometry.
  localparam int UNITS    = 4;
  localparam int CHANNELS = 8;
  localparam int ENTRIES  = UNITS * CHANNELS;
  localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_CAL_OFFSET     = 2'd2;
  localparam logic [1:0] REG_ENABLE_MASK    = 2'd3;

  // Operation codes of an input item.
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SET_MODE = 1'b1;

  // Entry mode codes.
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_FORCED_ON  = 2'd1;
  localparam logic [1:0] MODE_FORCED_OFF = 2'd2;

  // Sample fault handling, in tenths of a degree.
  localparam logic signed [11:0] FAULT_LIMIT_TENTHS = -12'sd400;
  localparam logic signed [12:0] FAULT_VALUE_TENTHS = -13'sd3000;

  // What the back has to do with a queued command.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_IGNORE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    kind_e                   kind;
    logic [ADDR_W-1:0]       addr;
    logic [2:0]              chan;
    logic signed [12:0]      temp;
    logic [1:0]              mode;
  } cmd_t;

  // One thermostat entry as kept in the table memory.
  typedef struct packed {
    logic               on;
    logic signed [12:0] temp;
    logic [15:0]        toggles;
    logic               dirty;
    logic [1:0]         mode;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    on:      1'b1,
    temp:    13'sd0,
    toggles: 16'd0,
    dirty:   1'b1,
    mode:    MODE_NORMAL
  };

  // Shared configuration registers.
  typedef struct packed {
    logic signed [7:0] low_threshold;
    logic signed [7:0] high_threshold;
    logic signed [7:0] cal_offset;
    logic [7:0]        enable_mask;
  } cfg_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Whole degrees to tenths by shift and add: 8x + 2x.
  function automatic logic signed [11:0] times_ten(input logic signed [7:0] deg);
    logic signed [11:0] ext;
    ext = {{4{deg[7]}}, deg};
    return (ext <<< 3) + (ext <<< 1);
  endfunction

endpackage

// File: design/mht_front.sv
// Front end: takes input items, checks the entry index and prepares the
// stored temperature. Depends on mht_pkg.
module mht_front import mht_pkg::*; (
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [1:0]         unit_index_i,
  input  logic [2:0]         channel_index_i,
  input  logic signed [11:0] sample_tenths_i,
  input  logic [1:0]         new_mode_i,
  input  cfg_t               cfg_i,
  input  qstat_t             qstat_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic               in_range;
  logic signed [12:0] cal_temp;

  // The front stalls only when the queue has no free slot.
  assign busy_o = qstat_i.full;
  assign push_o = start_i && !qstat_i.full;

  assign in_range = (int'(unit_index_i) < UNITS) && (int'(channel_index_i) < CHANNELS);

  // Calibrated temperature, or the fault marker for a sample below the limit.
  always_comb begin
    if (sample_tenths_i < FAULT_LIMIT_TENTHS) begin
      cal_temp = FAULT_VALUE_TENTHS;
    end else begin
      cal_temp = {sample_tenths_i[11], sample_tenths_i}
               + {{5{cfg_i.cal_offset[7]}}, cfg_i.cal_offset};
    end
  end

  // Classify the item for the back.
  always_comb begin
    cmd_o.addr = ADDR_W'(int'(unit_index_i) * CHANNELS + int'(channel_index_i));
    cmd_o.chan = channel_index_i;
    cmd_o.temp = cal_temp;
    cmd_o.mode = new_mode_i;
    if (!in_range) begin
      cmd_o.kind = KIND_NONE;
    end else if (op_i == OP_SAMPLE) begin
      cmd_o.kind = KIND_SAMPLE;
    end else if (new_mode_i == MODE_NORMAL || new_mode_i == MODE_FORCED_ON
                 || new_mode_i == MODE_FORCED_OFF) begin
      cmd_o.kind = KIND_MODE;
    end else begin
      cmd_o.kind = KIND_IGNORE;
    end
  end

endmodule

// File: design/mht_queue.sv
// Short command queue between the front and the back.
// Depends on mht_pkg for the command type and the depth.
module mht_queue import mht_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  input  logic   pop_i,
  output cmd_t   head_o,
  output qstat_t qstat_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("command transfer into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("command taken from an empty queue");
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not follow a push");
`endif

endmodule

// File: design/mht_back.sv
// Back end: reads a thermostat entry, applies the hysteresis control or mode
// change, writes the entry back and issues the result. Depends on mht_pkg.
module mht_back import mht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               head_i,
  input  qstat_t             qstat_i,
  output logic               pop_o,
  output logic               done_o,
  output logic               output_on_o,
  output logic signed [12:0] stored_tenths_o,
  output logic [15:0]        toggle_count_o,
  output logic               dirty_o,
  output logic               changed_now_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e              state_q, state_d;
  entry_t              mem [ENTRIES];
  entry_t              rd_q;
  logic [ENTRIES-1:0]  valid_q;
  logic                rd_valid_q;
  cmd_t                cmd_q;
  entry_t              ent;
  entry_t              nxt;
  logic                chg;
  logic                we;
  logic signed [11:0]  lo_x10;
  logic signed [11:0]  hi_x10;
  logic signed [12:0]  lo_tenths;
  logic signed [12:0]  hi_tenths;
  logic                on_cond;
  logic                off_cond;
  logic                done_q;
  logic                on_q;
  logic signed [12:0]  temp_q;
  logic [15:0]         toggles_q;
  logic                dirty_q;
  logic                chg_q;

  // Sequencer: the entry is read when the command is taken from the queue and updated in the cycle after.
  assign pop_o = (state_q == ST_IDLE) && !qstat_i.empty;
  assign we    = (state_q == ST_EXEC) && (cmd_q.kind != KIND_NONE);

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = pop_o ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cmd_q.addr] <= nxt;
    end
    if (pop_o) begin
      rd_q  <= mem[head_i.addr];
      cmd_q <= head_i;
    end
  end

  // Valid bits: an entry never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[cmd_q.addr] <= 1'b1;
      end
      if (pop_o) begin
        rd_valid_q <= valid_q[head_i.addr];
      end
    end
  end

  assign ent = rd_valid_q ? rd_q : ENTRY_RESET;

  // Hysteresis thresholds in tenths of a degree.
  assign lo_x10    = times_ten(cfg_i.low_threshold);
  assign hi_x10    = times_ten(cfg_i.high_threshold);
  assign lo_tenths = {lo_x10[11], lo_x10};
  assign hi_tenths = {hi_x10[11], hi_x10};

  assign on_cond  = (ent.mode == MODE_FORCED_ON)
                 || ((ent.mode == MODE_NORMAL) && (cmd_q.temp <= lo_tenths));
  assign off_cond = (ent.mode == MODE_FORCED_OFF) || (cmd_q.temp >= hi_tenths);

  // Entry update for the command in flight.
  always_comb begin
    nxt = ent;
    chg = 1'b0;
    case (cmd_q.kind)
      KIND_SAMPLE: begin
        nxt.temp = cmd_q.temp;
        if (cmd_q.temp != ent.temp) begin
          chg = 1'b1;
        end
        if (cfg_i.enable_mask[cmd_q.chan]) begin
          if (on_cond) begin
            nxt.on = 1'b1;
          end else if (off_cond) begin
            nxt.on = 1'b0;
          end
        end
        if (nxt.on != ent.on) begin
          nxt.toggles = ent.toggles + 16'd1;
          chg         = 1'b1;
        end
      end
      KIND_MODE: begin
        if (cmd_q.mode != ent.mode) begin
          nxt.mode = cmd_q.mode;
          chg      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    nxt.dirty = ent.dirty | chg;
  end

  // Result register: shown for exactly one cycle after the update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      if (cmd_q.kind == KIND_NONE) begin
        on_q      <= 1'b0;
        temp_q    <= '0;
        toggles_q <= '0;
        dirty_q   <= 1'b0;
        chg_q     <= 1'b0;
      end else begin
        on_q      <= nxt.on;
        temp_q    <= nxt.temp;
        toggles_q <= nxt.toggles;
        dirty_q   <= nxt.dirty;
        chg_q     <= chg;
      end
    end
  end

  assign done_o          = done_q;
  assign output_on_o     = on_q;
  assign stored_tenths_o = temp_q;
  assign toggle_count_o  = toggles_q;
  assign dirty_o         = dirty_q;
  assign changed_now_o   = chg_q;

`ifndef NO_ASSERTIONS
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_q)
    else $error("update cycle gave no result strobe");
  a_done_only_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC))
    else $error("result strobe without an update cycle");
  a_pop_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_EXEC))
    else $error("command taken from the queue but not carried out");
  a_changed_sets_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && chg_q) |-> dirty_q)
    else $error("entry changed without its dirty flag");
`endif

endmodule

// File: design/multichannel_hysteresis_thermostat.sv
// Multichannel hysteresis thermostat: with the queue empty, the back reads the entry after the
// item transfer, then writes it and the result register, which raises the strobe; the result
// is taken while the strobe is high. The back takes a new item only after it has updated the
// entry of the last one, so a queued item waits for the read and update of each item ahead.
// Reset clears the entry valid bits at once, so no clearing pass runs; the
// registers return to their defaults. The receiver cannot stall results.
module multichannel_hysteresis_thermostat import mht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [1:0]         unit_index_i,
  input  logic [2:0]         channel_index_i,
  input  logic signed [11:0] sample_tenths_i,
  input  logic [1:0]         new_mode_i,
  output logic               done_o,
  output logic               output_on_o,
  output logic signed [12:0] stored_tenths_o,
  output logic [15:0]        toggle_count_o,
  output logic               dirty_o,
  output logic               changed_now_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cfg_t   cfg_q;
  qstat_t qstat;
  logic   push;
  logic   pop;
  cmd_t   cmd_in;
  cmd_t   cmd_head;

  // Configuration registers; a write transfer is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= 8'sd20;
      cfg_q.high_threshold <= 8'sd22;
      cfg_q.cal_offset     <= 8'sd0;
      cfg_q.enable_mask    <= 8'hFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_data_i;
        REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_data_i;
        REG_CAL_OFFSET:     cfg_q.cal_offset     <= cfg_data_i;
        REG_ENABLE_MASK:    cfg_q.enable_mask    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mht_front u_front (
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .unit_index_i    (unit_index_i),
    .channel_index_i (channel_index_i),
    .sample_tenths_i (sample_tenths_i),
    .new_mode_i      (new_mode_i),
    .cfg_i           (cfg_q),
    .qstat_i         (qstat),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  mht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .head_o  (cmd_head),
    .qstat_o (qstat)
  );

  mht_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (cmd_head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .done_o          (done_o),
    .output_on_o     (output_on_o),
    .stored_tenths_o (stored_tenths_o),
    .toggle_count_o  (toggle_count_o),
    .dirty_o         (dirty_o),
    .changed_now_o   (changed_now_o)
  );

endmodule

// File: tb/tb.sv
// Testbench of the multichannel hysteresis thermostat: directed and random items checked
// against an entry table kept in the testbench. Depends on mht_pkg and on the top module.
`timescale 1ns / 100ps

module tb;
  import mht_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 40;
  localparam int SETTLE_CYCLES  = 4;

  // One result as the block should show it.
  typedef struct {
    logic               on;
    logic signed [12:0] tenths;
    logic [15:0]        toggles;
    logic               dirty;
    logic               changed;
  } reading_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               start_i         = 1'b0;
  logic               busy_o;
  logic               op_i            = OP_SAMPLE;
  logic [1:0]         unit_index_i    = '0;
  logic [2:0]         channel_index_i = '0;
  logic signed [11:0] sample_tenths_i = '0;
  logic [1:0]         new_mode_i      = MODE_NORMAL;
  logic               done_o;
  logic               output_on_o;
  logic signed [12:0] stored_tenths_o;
  logic [15:0]        toggle_count_o;
  logic               dirty_o;
  logic               changed_now_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i     = REG_LOW_THRESHOLD;
  logic [7:0]         cfg_data_i      = '0;

  // Predicted configuration, starting at the reset defaults.
  logic signed [7:0] low_thr     = 8'sd20;
  logic signed [7:0] high_thr    = 8'sd22;
  logic signed [7:0] cal_offset  = 8'sd0;
  logic [7:0]        enable_mask = 8'hFF;

  // Predicted entry table.
  logic signed [12:0] temp_tbl[ENTRIES]    = '{default: 13'sd0};
  logic               on_tbl[ENTRIES]      = '{default: 1'b1};
  logic               dirty_tbl[ENTRIES]   = '{default: 1'b1};
  logic [1:0]         mode_tbl[ENTRIES]    = '{default: MODE_NORMAL};
  logic [15:0]        toggles_tbl[ENTRIES] = '{default: 16'd0};

  reading_t pending_readings[$];
  int       mismatch_count = 0;
  int       result_count   = 0;
  int       quiet_cycles   = 0;
  int       gap_pct        = 0;

  multichannel_hysteresis_thermostat u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .unit_index_i    (unit_index_i),
    .channel_index_i (channel_index_i),
    .sample_tenths_i (sample_tenths_i),
    .new_mode_i      (new_mode_i),
    .done_o          (done_o),
    .output_on_o     (output_on_o),
    .stored_tenths_o (stored_tenths_o),
    .toggle_count_o  (toggle_count_o),
    .dirty_o         (dirty_o),
    .changed_now_o   (changed_now_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one item to the predicted table and return the entry as it should read after it.
  function automatic reading_t thermostat_update(logic op, logic [1:0] unit_idx,
                                                 logic [2:0] chan_idx,
                                                 logic signed [11:0] sample_v,
                                                 logic [1:0] mode_v);
    reading_t r;
    int       e;
    int       t;
    int       lo;
    int       hi;
    logic     changed;
    logic     drive;
    logic     target;
    r = '{on: 1'b0, tenths: 13'sd0, toggles: 16'd0, dirty: 1'b0, changed: 1'b0};
    changed = 1'b0;
    drive = 1'b0;
    target = 1'b0;
    if (int'(unit_idx) >= UNITS || int'(chan_idx) >= CHANNELS) return r;
    e = int'(unit_idx) * CHANNELS + int'(chan_idx);
    if (op == OP_SAMPLE) begin
      // Samples below the fault limit are replaced by the fault marker.
      if (sample_v < FAULT_LIMIT_TENTHS) t = int'(FAULT_VALUE_TENTHS);
      else t = int'(sample_v) + int'(cal_offset);
      if (t != int'(temp_tbl[e])) begin
        temp_tbl[e] = 13'(t);
        changed = 1'b1;
      end
      // The on test comes first, so crossed thresholds favor turning on.
      if (enable_mask[chan_idx]) begin
        lo = int'(low_thr) * 10;
        hi = int'(high_thr) * 10;
        if (mode_tbl[e] == MODE_FORCED_ON || (mode_tbl[e] == MODE_NORMAL && t <= lo)) begin
          drive = 1'b1;
          target = 1'b1;
        end else if (mode_tbl[e] == MODE_FORCED_OFF || t >= hi) begin
          drive = 1'b1;
          target = 1'b0;
        end
      end
      if (drive && on_tbl[e] != target) begin
        on_tbl[e] = target;
        toggles_tbl[e] = toggles_tbl[e] + 16'd1;
        changed = 1'b1;
      end
    end else if (mode_v <= MODE_FORCED_OFF && mode_tbl[e] != mode_v) begin
      mode_tbl[e] = mode_v;
      changed = 1'b1;
    end
    if (changed) dirty_tbl[e] = 1'b1;
    r.on = on_tbl[e];
    r.tenths = temp_tbl[e];
    r.toggles = toggles_tbl[e];
    r.dirty = dirty_tbl[e];
    r.changed = changed;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
    mismatch_count++;
  endtask

  // Result checking, prediction at each item transfer, configuration tracking and watchdog.
  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (done_o) begin
        quiet_cycles = 0;
        if (pending_readings.size() == 0) begin
          report_mismatch("result with no pending item", 1, 0);
        end else begin
          want = pending_readings.pop_front();
          if (output_on_o !== want.on)
            report_mismatch("output_on", output_on_o, want.on);
          if (stored_tenths_o !== want.tenths)
            report_mismatch("stored_tenths", stored_tenths_o, want.tenths);
          if (toggle_count_o !== want.toggles)
            report_mismatch("toggle_count", toggle_count_o, want.toggles);
          if (dirty_o !== want.dirty)
            report_mismatch("dirty", dirty_o, want.dirty);
          if (changed_now_o !== want.changed)
            report_mismatch("changed_now", changed_now_o, want.changed);
        end
        result_count++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles = 0;
        case (cfg_index_i)
          REG_LOW_THRESHOLD:  low_thr = cfg_data_i;
          REG_HIGH_THRESHOLD: high_thr = cfg_data_i;
          REG_CAL_OFFSET:     cal_offset = cfg_data_i;
          REG_ENABLE_MASK:    enable_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        quiet_cycles = 0;
        pending_readings.push_back(thermostat_update(op_i, unit_index_i, channel_index_i,
                                                     sample_tenths_i, new_mode_i));
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 quiet_cycles, pending_readings.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one item and hold it until its transfer, then maybe leave an idle burst.
  task automatic send_item(logic op, int unit_idx, int chan_idx, int tenths, logic [1:0] mode_v);
    start_i <= 1'b1;
    op_i <= op;
    unit_index_i <= 2'(unit_idx);
    channel_index_i <= 3'(chan_idx);
    sample_tenths_i <= 12'(tenths);
    new_mode_i <= mode_v;
    do @(posedge clk_i); while (busy_o);
    if (gap_pct > 0 && int'($urandom_range(0, 99)) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come, plus a short settle.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers while the block is idle.
  task automatic program_config(int lo, int hi, int cal, int mask);
    logic [1:0] regs[4];
    logic [7:0] vals[4];
    regs = '{REG_LOW_THRESHOLD, REG_HIGH_THRESHOLD, REG_CAL_OFFSET, REG_ENABLE_MASK};
    vals = '{8'(lo), 8'(hi), 8'(cal), 8'(mask)};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Reset thresholds: on at or below 200 tenths, off at or above 220, fault boundary.
  task automatic test_default_hysteresis();
    send_item(OP_SAMPLE, 0, 0, 200, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 0, 210, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 0, 220, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 0, 210, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 1, -400, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 1, -401, MODE_NORMAL);
    send_item(OP_SAMPLE, 0, 2, 2047, MODE_NORMAL);
    send_item(OP_SAMPLE, 3, 7, -2048, MODE_NORMAL);
  endtask

  // Forced modes, a repeated mode, the unused mode code and the return to normal.
  task automatic test_mode_items();
    send_item(OP_SET_MODE, 1, 2, 0, MODE_FORCED_ON);
    send_item(OP_SET_MODE, 1, 2, 0, MODE_FORCED_ON);
    send_item(OP_SAMPLE, 1, 2, 2000, MODE_NORMAL);
    send_item(OP_SET_MODE, 1, 2, 0, MODE_FORCED_OFF);
    send_item(OP_SAMPLE, 1, 2, -100, MODE_NORMAL);
    send_item(OP_SET_MODE, 1, 2, 0, 2'd3);
    send_item(OP_SET_MODE, 1, 2, 0, MODE_NORMAL);
    send_item(OP_SAMPLE, 1, 2, -100, MODE_NORMAL);
  endtask

  // A masked channel stores its sample but keeps its output.
  task automatic test_disabled_channel();
    program_config(20, 22, 0, 8'hFE);
    send_item(OP_SAMPLE, 2, 0, 2000, MODE_NORMAL);
    send_item(OP_SAMPLE, 2, 1, 2000, MODE_NORMAL);
  endtask

  // Low above high, then the register extremes.
  task automatic test_thresholds_and_offsets();
    program_config(30, 10, 0, 8'hFF);
    send_item(OP_SAMPLE, 2, 2, 200, MODE_NORMAL);
    send_item(OP_SAMPLE, 2, 2, 400, MODE_NORMAL);
    program_config(-40, 125, 127, 8'hFF);
    send_item(OP_SAMPLE, 2, 3, -400, MODE_NORMAL);
    send_item(OP_SAMPLE, 2, 3, 2047, MODE_NORMAL);
    send_item(OP_SAMPLE, 2, 3, -2048, MODE_NORMAL);
    program_config(-40, 125, -127, 8'h00);
    send_item(OP_SAMPLE, 2, 4, -400, MODE_NORMAL);
    program_config(20, 22, 0, 8'hFF);
  endtask

  // Drive one entry on and off with back-to-back items so every sample toggles it.
  task automatic test_toggle_count();
    gap_pct = 0;
    for (int i = 0; i < 40; i++)
      send_item(OP_SAMPLE, 3, 6, (i % 2 == 0) ? 1000 : 0, MODE_NORMAL);
  endtask

  // Sample values clustered at the thresholds and the fault limit, with some full-range noise.
  function automatic int pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($signed(12'($urandom)));
      2: v = -400 + int'($urandom_range(0, 6)) - 3;
      default: begin
        v = (($urandom_range(0, 1) == 0) ? int'(low_thr) : int'(high_thr)) * 10;
        v = v - int'(cal_offset) + int'($urandom_range(0, 50)) - 25;
      end
    endcase
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  // One phase: a random configuration, then random items aimed partly at two busy entries.
  task automatic test_random_phase(int items, int idle_pct);
    int lo;
    int hi;
    int cal;
    int mask;
    int hot_unit[2];
    int hot_chan[2];
    int u;
    int c;
    int k;
    case ($urandom_range(0, 9))
      6: begin
        hi = int'($urandom_range(0, 140)) - 40;
        lo = hi + int'($urandom_range(1, 20));
      end
      7: begin
        lo = int'($urandom_range(0, 165)) - 40;
        hi = lo;
      end
      8: begin
        lo = int'($signed(8'($urandom)));
        hi = int'($signed(8'($urandom)));
      end
      9: begin
        lo = -40;
        hi = 125;
      end
      default: begin
        lo = int'($urandom_range(0, 150)) - 40;
        hi = lo + int'($urandom_range(1, 15));
        if (hi > 125) hi = 125;
      end
    endcase
    case ($urandom_range(0, 5))
      0: cal = 0;
      1: cal = int'($signed(8'($urandom)));
      default: cal = int'($urandom_range(0, 254)) - 127;
    endcase
    case ($urandom_range(0, 7))
      0, 1: mask = 8'hFF;
      2: mask = 8'h00;
      default: mask = int'($urandom_range(0, 255));
    endcase
    program_config(lo, hi, cal, mask);
    gap_pct = idle_pct;
    for (int i = 0; i < 2; i++) begin
      hot_unit[i] = int'($urandom_range(0, 3));
      hot_chan[i] = int'($urandom_range(0, 7));
    end
    for (int i = 0; i < items; i++) begin
      // Halfway through, let the pipeline empty once before carrying on.
      if (i == items / 2) drain_results();
      if ($urandom_range(0, 1) == 0) begin
        k = int'($urandom_range(0, 1));
        u = hot_unit[k];
        c = hot_chan[k];
      end else begin
        u = int'($urandom_range(0, 3));
        c = int'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 4) == 0)
        send_item(OP_SET_MODE, u, c, int'($signed(12'($urandom))), 2'($urandom_range(0, 3)));
      else
        send_item(OP_SAMPLE, u, c, pick_sample(), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 30;
    test_default_hysteresis();
    test_mode_items();
    test_disabled_channel();
    test_thresholds_and_offsets();
    test_toggle_count();
    test_random_phase(250, 30);
    test_random_phase(250, 0);
    test_random_phase(250, 60);
    test_random_phase(250, 15);
    test_random_phase(250, 40);
    test_random_phase(250, 25);
    test_random_phase(200, 0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_readings.size() != 0)
      report_mismatch("results never came", 0, pending_readings.size());
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
